// ===== src/cbtf_pkg.sv =====
// Shared widths, constants and types for the cubic Bezier tangent frame.
package cbtf_pkg;

    localparam int COORD_W    = 20;
    localparam int PARAM_FRAC = 12;
    localparam int UNIT_FRAC  = 14;

    localparam int CFG_W     = 60;
    localparam int CFG_N     = 4;
    localparam int CFG_IDX_W = 2;

    localparam int PRM_W = PARAM_FRAC + 1;
    localparam int UU_W  = 2 * PRM_W;
    localparam int DIF_W = COORD_W + 1;
    localparam int WT_W  = 2 * PARAM_FRAC + 3;
    localparam int PR_W  = WT_W + DIF_W + 1;
    localparam int D_W   = COORD_W + 2 * PARAM_FRAC + 4;

    localparam int OUT_W  = UNIT_FRAC + 2;
    localparam int MAG_W  = 30;
    localparam int ROOT_W = MAG_W + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int QB     = UNIT_FRAC + 1;
    localparam int DV_W   = ROOT_W + QB;

    localparam int SC_W = OUT_W + 1;
    localparam int XP_W = 2 * OUT_W;
    localparam int LC_W = 2 * OUT_W - 1;

    localparam logic [PRM_W-1:0] PARAM_ONE = PRM_W'(1 << PARAM_FRAC);
    localparam logic [QB-1:0]    UNIT_MAG  = QB'(1 << UNIT_FRAC);

    typedef logic signed [OUT_W-1:0] t_unit;

    localparam t_unit UNIT_POS  = t_unit'(1 << UNIT_FRAC);
    localparam t_unit UNIT_NEG  = t_unit'(-(1 << UNIT_FRAC));
    // forward.y >= 0.99 in Q1.14, rounded up to the next code
    localparam t_unit UP_THRESH = t_unit'((99 * (1 << UNIT_FRAC) + 99) / 100);

endpackage

// ===== src/cbtf_norm.sv =====
// Pipelined vector normaliser: scale, squares, bit-serial square root, divide.
module cbtf_norm import cbtf_pkg::*; #(
    parameter int IN_W   = 48,
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [IN_W-1:0]  i_comp [3],
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output t_unit                   o_unit [3],
    output logic                    o_ok,
    output logic [SIDE_W-1:0]       o_side
);

    localparam int SH_W = $clog2(IN_W + 1);
    localparam int SQ_W = 2 * MAG_W;

    // stage A: magnitudes and signs
    logic              r_a_v;
    logic [IN_W-1:0]   r_a_mag [3];
    logic [2:0]        r_a_sgn;
    logic [SIDE_W-1:0] r_a_side;

    // stage B: scale shift
    logic              r_b_v;
    logic [IN_W-1:0]   r_b_mag [3];
    logic [SH_W-1:0]   r_b_s;
    logic [2:0]        r_b_sgn;
    logic [SIDE_W-1:0] r_b_side;
    logic [IN_W-1:0]   n_any;
    logic [SH_W-1:0]   n_nb;
    logic [SH_W-1:0]   n_s;

    // stage C: scaled magnitudes
    logic              r_c_v;
    logic [MAG_W-1:0]  r_c_mag [3];
    logic [2:0]        r_c_sgn;
    logic [SIDE_W-1:0] r_c_side;

    // stage D: squares
    logic              r_d_v;
    logic [MAG_W-1:0]  r_d_mag [3];
    logic [SQ_W-1:0]   r_d_sq [3];
    logic [2:0]        r_d_sgn;
    logic [SIDE_W-1:0] r_d_side;

    // square root stages, index 0 holds the radicand
    logic              r_q_v    [ROOT_W+1];
    logic [RAD_W-1:0]  r_q_x    [ROOT_W+1];
    logic [REM_W-1:0]  r_q_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_q_root [ROOT_W+1];
    logic [MAG_W-1:0]  r_q_mag  [ROOT_W+1][3];
    logic [2:0]        r_q_sgn  [ROOT_W+1];
    logic [SIDE_W-1:0] r_q_side [ROOT_W+1];
    logic [RAD_W-1:0]  n_q_x    [ROOT_W];
    logic [REM_W-1:0]  n_q_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_q_root [ROOT_W];
    logic [REM_W+1:0]  n_q_cur  [ROOT_W];
    logic [REM_W+1:0]  n_q_try  [ROOT_W];

    // divide stages, index 0 holds numerators and divisor
    logic              r_v_v    [QB+1];
    logic [DV_W-1:0]   r_v_rem  [QB+1][3];
    logic [QB-1:0]     r_v_q    [QB+1][3];
    logic [ROOT_W-1:0] r_v_den  [QB+1];
    logic              r_v_ok   [QB+1];
    logic [2:0]        r_v_sgn  [QB+1];
    logic [SIDE_W-1:0] r_v_side [QB+1];
    logic [DV_W-1:0]   n_v_rem  [QB][3];
    logic [QB-1:0]     n_v_q    [QB][3];
    logic [DV_W-1:0]   n_v_try  [QB];

    logic [QB-1:0]     n_o_q [3];
    logic [ROOT_W-1:0] w_len;

    always_comb begin
        n_any = r_a_mag[0] | r_a_mag[1] | r_a_mag[2];
        n_nb  = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (n_any[i]) begin
                n_nb = SH_W'(i + 1);
            end
        end
        n_s = (int'(n_nb) > MAG_W) ? SH_W'(int'(n_nb) - MAG_W) : '0;
    end

    // one root bit per stage
    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            n_q_cur[k] = {r_q_rem[k], r_q_x[k][RAD_W-1 -: 2]};
            n_q_try[k] = (REM_W + 2)'({r_q_root[k], 2'b01});
            n_q_x[k]   = r_q_x[k] << 2;
            if (n_q_cur[k] >= n_q_try[k]) begin
                n_q_rem[k]  = REM_W'(n_q_cur[k] - n_q_try[k]);
                n_q_root[k] = {r_q_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_q_rem[k]  = REM_W'(n_q_cur[k]);
                n_q_root[k] = {r_q_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // one quotient bit per stage, most significant first
    always_comb begin
        for (int j = 0; j < QB; j++) begin
            n_v_try[j] = DV_W'(r_v_den[j]) << (QB - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (r_v_rem[j][i] >= n_v_try[j]) begin
                    n_v_rem[j][i] = r_v_rem[j][i] - n_v_try[j];
                    n_v_q[j][i]   = r_v_q[j][i] | (QB'(1) << (QB - 1 - j));
                end else begin
                    n_v_rem[j][i] = r_v_rem[j][i];
                    n_v_q[j][i]   = r_v_q[j][i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_o_q[i] = (r_v_q[QB][i] > UNIT_MAG) ? UNIT_MAG : r_v_q[QB][i];
        end
    end

    assign w_len = r_q_root[ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            for (int k = 0; k <= ROOT_W; k++) begin
                r_q_v[k] <= 1'b0;
            end
            for (int j = 0; j <= QB; j++) begin
                r_v_v[j] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_a_v    <= i_valid;
            r_b_v    <= r_a_v;
            r_c_v    <= r_b_v;
            r_d_v    <= r_c_v;
            r_q_v[0] <= r_d_v;
            for (int k = 0; k < ROOT_W; k++) begin
                r_q_v[k+1] <= r_q_v[k];
            end
            r_v_v[0] <= r_q_v[ROOT_W];
            for (int j = 0; j < QB; j++) begin
                r_v_v[j+1] <= r_v_v[j];
            end
            o_valid <= r_v_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_mag[i] <= (i_comp[i] < 0) ? IN_W'(-i_comp[i]) : IN_W'(i_comp[i]);
                r_a_sgn[i] <= i_comp[i] < 0;
            end
            r_a_side <= i_side;

            r_b_mag  <= r_a_mag;
            r_b_s    <= n_s;
            r_b_sgn  <= r_a_sgn;
            r_b_side <= r_a_side;

            for (int i = 0; i < 3; i++) begin
                r_c_mag[i] <= MAG_W'(r_b_mag[i] >> r_b_s);
            end
            r_c_sgn  <= r_b_sgn;
            r_c_side <= r_b_side;

            for (int i = 0; i < 3; i++) begin
                r_d_sq[i] <= SQ_W'(r_c_mag[i]) * SQ_W'(r_c_mag[i]);
            end
            r_d_mag  <= r_c_mag;
            r_d_sgn  <= r_c_sgn;
            r_d_side <= r_c_side;

            r_q_x[0]    <= RAD_W'(r_d_sq[0]) + RAD_W'(r_d_sq[1]) + RAD_W'(r_d_sq[2]);
            r_q_rem[0]  <= '0;
            r_q_root[0] <= '0;
            r_q_mag[0]  <= r_d_mag;
            r_q_sgn[0]  <= r_d_sgn;
            r_q_side[0] <= r_d_side;
            for (int k = 0; k < ROOT_W; k++) begin
                r_q_x[k+1]    <= n_q_x[k];
                r_q_rem[k+1]  <= n_q_rem[k];
                r_q_root[k+1] <= n_q_root[k];
                r_q_mag[k+1]  <= r_q_mag[k];
                r_q_sgn[k+1]  <= r_q_sgn[k];
                r_q_side[k+1] <= r_q_side[k];
            end

            // round half up: add half the length before dividing
            for (int i = 0; i < 3; i++) begin
                r_v_rem[0][i] <= (DV_W'(r_q_mag[ROOT_W][i]) << UNIT_FRAC)
                               + DV_W'(w_len >> 1);
                r_v_q[0][i]   <= '0;
            end
            r_v_den[0]  <= w_len;
            r_v_ok[0]   <= w_len != '0;
            r_v_sgn[0]  <= r_q_sgn[ROOT_W];
            r_v_side[0] <= r_q_side[ROOT_W];
            for (int j = 0; j < QB; j++) begin
                r_v_rem[j+1]  <= n_v_rem[j];
                r_v_q[j+1]    <= n_v_q[j];
                r_v_den[j+1]  <= r_v_den[j];
                r_v_ok[j+1]   <= r_v_ok[j];
                r_v_sgn[j+1]  <= r_v_sgn[j];
                r_v_side[j+1] <= r_v_side[j];
            end

            for (int i = 0; i < 3; i++) begin
                if (!r_v_ok[QB]) begin
                    o_unit[i] <= '0;
                end else if (r_v_sgn[QB][i]) begin
                    o_unit[i] <= t_unit'(0) - t_unit'(n_o_q[i]);
                end else begin
                    o_unit[i] <= t_unit'(n_o_q[i]);
                end
            end
            o_ok   <= r_v_ok[QB];
            o_side <= r_v_side[QB];
        end
    end

endmodule

// ===== src/cubic_bezier_tangent_frame.sv =====
// Cubic Bezier tangent frame: derivative, forward/side/lift unit vectors.
//
// Load the four control points through the write port (i_cfg_we, i_cfg_idx,
// i_cfg_data) while no transaction is in flight. Each input transaction on
// i_in_valid/o_in_stall carries one parameter t (unsigned Q1.12, saturated at 1.0);
// each output transaction on o_out_valid/i_out_stall carries forward, side
// and lift in signed Q1.14 plus the degenerate flag.
// The pipeline consists of the derivative stages, then the three normalisers
// (each with one square-root bit and then one quotient bit per stage), the
// up-vector choice and the second cross product.
// Throughput is one transaction per cycle unless stalled. The pipeline
// advances as a whole; while a result is held at the output under stall,
// every stage holds and o_in_stall is raised, so nothing is lost or repeated.
// Reset clears all valid bits and the control points to zero; the output is
// empty after reset.
// A zero-length vector gives zero for itself and all vectors built from it,
// and raises o_degenerate.
module cubic_bezier_tangent_frame import cbtf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PRM_W-1:0]     i_curve_param,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_unit                o_forward_x,
    output t_unit                o_forward_y,
    output t_unit                o_forward_z,
    output t_unit                o_side_x,
    output t_unit                o_side_y,
    output t_unit                o_side_z,
    output t_unit                o_lift_x,
    output t_unit                o_lift_y,
    output t_unit                o_lift_z,
    output logic                 o_degenerate
);

    localparam int FW_W  = 3 * OUT_W;
    localparam int S2_W  = FW_W + 1;
    localparam int S3_W  = 2 * FW_W + 1;

    logic w_en;

    logic [CFG_W-1:0] r_ctrl [CFG_N];

    logic                     r_s1_v;
    logic [PRM_W-1:0]         r_s1_t;
    logic [PRM_W-1:0]         r_s1_u;
    logic signed [DIF_W-1:0]  r_s1_dif [3][3];
    logic [PRM_W-1:0]         n_s1_t;
    logic signed [DIF_W-1:0]  n_s1_dif [3][3];

    logic                     r_s2_v;
    logic [UU_W-1:0]          r_s2_m [3];
    logic signed [DIF_W-1:0]  r_s2_dif [3][3];

    logic                     r_s3_v;
    logic [WT_W-1:0]          r_s3_w [3];
    logic signed [DIF_W-1:0]  r_s3_dif [3][3];

    logic                     r_s4_v;
    logic signed [D_W-1:0]    r_s4_pr [3][3];

    logic                     r_s5_v;
    logic signed [D_W-1:0]    r_s5_d [3];

    logic                     w_n1_v;
    t_unit                    w_fw [3];
    logic                     w_n1_ok;
    logic                     w_n1_side;

    logic                     r_s6_v;
    logic signed [SC_W-1:0]   r_s6_sc [3];
    logic [S2_W-1:0]          r_s6_side;

    logic                     w_n2_v;
    t_unit                    w_sd [3];
    logic                     w_n2_ok;
    logic [S2_W-1:0]          w_n2_side;

    logic                     r_s7_v;
    logic signed [XP_W-1:0]   r_s7_p [6];
    logic [S3_W-1:0]          r_s7_side;

    logic                     r_s8_v;
    logic signed [LC_W-1:0]   r_s8_lc [3];
    logic [S3_W-1:0]          r_s8_side;

    t_unit                    w_lf [3];
    logic                     w_n3_ok;
    logic [S3_W-1:0]          w_n3_side;

    assign w_en       = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < CFG_N; p++) begin
                r_ctrl[p] <= '0;
            end
        end else if (i_cfg_we) begin
            r_ctrl[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        n_s1_t = (i_curve_param > PARAM_ONE) ? PARAM_ONE : i_curve_param;
        for (int g = 0; g < 3; g++) begin
            for (int a = 0; a < 3; a++) begin
                n_s1_dif[g][a] =
                    DIF_W'(signed'(r_ctrl[g+1][a*COORD_W +: COORD_W]))
                  - DIF_W'(signed'(r_ctrl[g][a*COORD_W +: COORD_W]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
            r_s8_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_in_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= w_n1_v;
            r_s7_v <= w_n2_v;
            r_s8_v <= r_s7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_t   <= n_s1_t;
            r_s1_u   <= PARAM_ONE - n_s1_t;
            r_s1_dif <= n_s1_dif;

            // basis products (1-t)^2, t(1-t), t^2
            r_s2_m[0] <= UU_W'(r_s1_u) * UU_W'(r_s1_u);
            r_s2_m[1] <= UU_W'(r_s1_t) * UU_W'(r_s1_u);
            r_s2_m[2] <= UU_W'(r_s1_t) * UU_W'(r_s1_t);
            r_s2_dif  <= r_s1_dif;

            r_s3_w[0] <= WT_W'(r_s2_m[0]) + (WT_W'(r_s2_m[0]) << 1);
            r_s3_w[1] <= (WT_W'(r_s2_m[1]) << 2) + (WT_W'(r_s2_m[1]) << 1);
            r_s3_w[2] <= WT_W'(r_s2_m[2]) + (WT_W'(r_s2_m[2]) << 1);
            r_s3_dif  <= r_s2_dif;

            for (int g = 0; g < 3; g++) begin
                for (int a = 0; a < 3; a++) begin
                    r_s4_pr[g][a] <= D_W'(PR_W'(signed'({1'b0, r_s3_w[g]}))
                                        * PR_W'(r_s3_dif[g][a]));
                end
            end

            for (int a = 0; a < 3; a++) begin
                r_s5_d[a] <= r_s4_pr[0][a] + r_s4_pr[1][a] + r_s4_pr[2][a];
            end

            // side = forward x up; up turns to +z when forward points nearly up
            if (w_fw[1] >= UP_THRESH) begin
                r_s6_sc[0] <= SC_W'(w_fw[1]);
                r_s6_sc[1] <= SC_W'(0) - SC_W'(w_fw[0]);
                r_s6_sc[2] <= '0;
            end else begin
                r_s6_sc[0] <= SC_W'(0) - SC_W'(w_fw[2]);
                r_s6_sc[1] <= '0;
                r_s6_sc[2] <= SC_W'(w_fw[0]);
            end
            r_s6_side <= {w_n1_side | !w_n1_ok, w_fw[2], w_fw[1], w_fw[0]};

            r_s7_p[0] <= XP_W'(w_sd[1]) * XP_W'(t_unit'(w_n2_side[2*OUT_W +: OUT_W]));
            r_s7_p[1] <= XP_W'(w_sd[2]) * XP_W'(t_unit'(w_n2_side[1*OUT_W +: OUT_W]));
            r_s7_p[2] <= XP_W'(w_sd[2]) * XP_W'(t_unit'(w_n2_side[0 +: OUT_W]));
            r_s7_p[3] <= XP_W'(w_sd[0]) * XP_W'(t_unit'(w_n2_side[2*OUT_W +: OUT_W]));
            r_s7_p[4] <= XP_W'(w_sd[0]) * XP_W'(t_unit'(w_n2_side[1*OUT_W +: OUT_W]));
            r_s7_p[5] <= XP_W'(w_sd[1]) * XP_W'(t_unit'(w_n2_side[0 +: OUT_W]));
            r_s7_side <= {w_n2_side[FW_W] | !w_n2_ok, w_sd[2], w_sd[1], w_sd[0],
                          w_n2_side[FW_W-1:0]};

            r_s8_lc[0] <= LC_W'(r_s7_p[0] - r_s7_p[1]);
            r_s8_lc[1] <= LC_W'(r_s7_p[2] - r_s7_p[3]);
            r_s8_lc[2] <= LC_W'(r_s7_p[4] - r_s7_p[5]);
            r_s8_side  <= r_s7_side;
        end
    end

    cbtf_norm #(
        .IN_W   (D_W),
        .SIDE_W (1)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s5_v),
        .i_comp  (r_s5_d),
        .i_side  (1'b0),
        .o_valid (w_n1_v),
        .o_unit  (w_fw),
        .o_ok    (w_n1_ok),
        .o_side  (w_n1_side)
    );

    cbtf_norm #(
        .IN_W   (SC_W),
        .SIDE_W (S2_W)
    ) u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s6_v),
        .i_comp  (r_s6_sc),
        .i_side  (r_s6_side),
        .o_valid (w_n2_v),
        .o_unit  (w_sd),
        .o_ok    (w_n2_ok),
        .o_side  (w_n2_side)
    );

    cbtf_norm #(
        .IN_W   (LC_W),
        .SIDE_W (S3_W)
    ) u_norm_lift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s8_v),
        .i_comp  (r_s8_lc),
        .i_side  (r_s8_side),
        .o_valid (o_out_valid),
        .o_unit  (w_lf),
        .o_ok    (w_n3_ok),
        .o_side  (w_n3_side)
    );

    assign o_forward_x  = t_unit'(w_n3_side[0 +: OUT_W]);
    assign o_forward_y  = t_unit'(w_n3_side[OUT_W +: OUT_W]);
    assign o_forward_z  = t_unit'(w_n3_side[2*OUT_W +: OUT_W]);
    assign o_side_x     = t_unit'(w_n3_side[FW_W +: OUT_W]);
    assign o_side_y     = t_unit'(w_n3_side[FW_W+OUT_W +: OUT_W]);
    assign o_side_z     = t_unit'(w_n3_side[FW_W+2*OUT_W +: OUT_W]);
    assign o_lift_x     = w_lf[0];
    assign o_lift_y     = w_lf[1];
    assign o_lift_z     = w_lf[2];
    assign o_degenerate = w_n3_side[2*FW_W] | !w_n3_ok;

`ifndef NO_ASSERTIONS
    a_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_forward_x <= UNIT_POS && o_forward_x >= UNIT_NEG &&
                         o_forward_y <= UNIT_POS && o_forward_y >= UNIT_NEG &&
                         o_forward_z <= UNIT_POS && o_forward_z >= UNIT_NEG))
        else $error("forward component outside unit range");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_degenerate) |->
            (o_forward_x != '0 || o_forward_y != '0 || o_forward_z != '0))
        else $error("zero forward vector without degenerate flag");

    a_zero_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_forward_x == '0 && o_forward_y == '0 && o_forward_z == '0)
        |-> (o_degenerate && o_side_x == '0 && o_side_y == '0 && o_side_z == '0 &&
             o_lift_x == '0 && o_lift_y == '0 && o_lift_z == '0))
        else $error("zero forward vector with non-zero frame");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_s1_v)
        else $error("accepted transaction not captured in first stage");
`endif

endmodule
